// ----- rtl/core/dds_pkg.sv -----
// Shared types, constants and helper function of the tone generator.
package dds_pkg;

   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned INTEG_W     = 11;
   localparam int unsigned PHASE_W     = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // floor(x / 100) == (x * PCT_RECIP) >> PCT_SHIFT for every x below 2^17.
   localparam logic [17:0] PCT_RECIP = 18'd167773;
   localparam int unsigned PCT_SHIFT = 24;
   localparam int unsigned PCT_PROD_W = 17;
   localparam int unsigned PCT_DIV_W  = 35;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 10'd1023;
   localparam logic [INTEG_W-1:0]  LEVEL_MASK = 11'h700;
   localparam logic [2:0]          LEVEL_MAX  = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [15:0] freq_hz;
      logic [6:0]  volume_pct;
      logic [7:0]  table_index;
      logic [9:0]  table_value;
   } dds_req_type;

   typedef struct packed {
      logic [3:0] pin_pattern;
      logic [5:0] word_index;
      logic       last;
   } dds_rsp_type;

   function automatic logic [3:0] level_to_pattern(input logic [2:0] level);
      logic [3:0] pattern;
      case (level)
         3'd0: pattern = 4'b0000;
         3'd1: pattern = 4'b1000;
         3'd2: pattern = 4'b1010;
         3'd3: pattern = 4'b1110;
         default: pattern = 4'b1111;
      endcase
      return pattern;
   endfunction

endpackage

// ----- rtl/core/dds_front.sv -----
// Front pipeline: phase step, wave table access and volume scaling.
module dds_front
   import dds_pkg::*;
#(
   parameter int unsigned SAMPLE_RATE_HZ = 16000
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  dds_req_type         req_word,
   output logic                sample_push,
   output logic [SAMPLE_W-1:0] sample_value,
   input  logic                sample_full
);

   // floor(2^32 / rate); the phase step estimate is at most one below the exact value.
   localparam longint unsigned RECIP = (64'd1 << 32) / SAMPLE_RATE_HZ;
   localparam int unsigned RECIP_W = $clog2(RECIP + 1);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
   localparam logic [31:0] RATE_C = 32'(SAMPLE_RATE_HZ);

   logic adv;

   logic                    s1_valid_ff, s1_valid_in;
   dds_req_type             s1_word_ff;
   logic [RECIP_W+15:0]     s1_prod_ff, s1_prod_in;

   logic                    s2_valid_ff;
   dds_req_type             s2_word_ff;
   logic [RECIP_W-1:0]      s2_q_ff, s2_q_in;
   logic [31:0]             s2_prod_ff, s2_prod_in;

   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic [31:0]             remainder;
   logic                    s2_tick, s2_write;

   logic [SAMPLE_W-1:0]     table_mem [256];
   logic                    s3_valid_ff;
   logic [SAMPLE_W-1:0]     s3_entry_ff;
   logic [6:0]              s3_pct_ff;

   logic                    s4_valid_ff;
   logic [PCT_PROD_W-1:0]   s4_prod_ff, s4_prod_in;

   logic                    s5_valid_ff;
   logic [PCT_DIV_W-1:0]    s5_prod_ff, s5_prod_in;
   logic [PCT_DIV_W-PCT_SHIFT-1:0] quotient;

   assign adv  = !s5_valid_ff || !sample_full;
   assign full = !adv;

   assign s1_valid_in = push;
   assign s1_prod_in  = {{RECIP_W{1'b0}}, req_word.freq_hz} * {16'h0, RECIP_C};

   assign s2_q_in    = s1_prod_ff[16 +: RECIP_W];
   assign s2_prod_in = 32'(s2_q_in) * RATE_C;

   // Correct the reciprocal estimate: one compare against the rate.
   assign remainder = {s2_word_ff.freq_hz, 16'h0} - s2_prod_ff;
   assign phase_in  = phase_ff + PHASE_W'(s2_q_ff) + PHASE_W'(remainder >= RATE_C);
   assign s2_tick   = s2_valid_ff && (s2_word_ff.kind == KIND_TICK);
   assign s2_write  = s2_valid_ff && (s2_word_ff.kind == KIND_WRITE);

   assign s4_prod_in = PCT_PROD_W'(s3_entry_ff) * PCT_PROD_W'(s3_pct_ff);
   assign s5_prod_in = PCT_DIV_W'(s4_prod_ff) * PCT_DIV_W'(PCT_RECIP);

   assign quotient     = s5_prod_ff[PCT_DIV_W-1:PCT_SHIFT];
   assign sample_push  = s5_valid_ff && !sample_full;
   assign sample_value = (quotient > (PCT_DIV_W-PCT_SHIFT)'(SAMPLE_MAX)) ?
                         SAMPLE_MAX : quotient[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         phase_ff    <= '0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_tick;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         if (s2_tick) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_word_ff <= req_word;
         s1_prod_ff <= s1_prod_in;
         s2_word_ff <= s1_word_ff;
         s2_q_ff    <= s2_q_in;
         s2_prod_ff <= s2_prod_in;
         s3_pct_ff  <= s2_word_ff.volume_pct;
         s4_prod_ff <= s4_prod_in;
         s5_prod_ff <= s5_prod_in;
      end
   end

   // Writes and reads reach the table in arrival order, one port access per cycle.
   always_ff @(posedge clock) begin
      if (adv && s2_write) begin
         table_mem[s2_word_ff.table_index] <= s2_word_ff.table_value;
      end
      if (adv && s2_tick) begin
         s3_entry_ff <= table_mem[phase_in[15:8]];
      end
   end

endmodule

// ----- rtl/core/dds_fifo.sv -----
// Short sample queue between the front pipeline and the modulator.
module dds_fifo
   import dds_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [SAMPLE_W-1:0] push_data,
   output logic                full,
   input  logic                pop,
   output logic [SAMPLE_W-1:0] pop_data,
   output logic                empty
);

   logic [SAMPLE_W-1:0]    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("sample queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("sample queue read while empty");
`endif

endmodule

// ----- rtl/core/dds_back.sv -----
// Sigma-delta modulator: one step and one word per cycle while busy and not stalled.
module dds_back
   import dds_pkg::*;
#(
   parameter int unsigned WORDS_PER_SAMPLE = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sample_empty,
   input  logic [SAMPLE_W-1:0] sample_value,
   output logic                sample_pop,
   output logic                empty,
   input  logic                pop,
   output dds_rsp_type         rsp_word
);

   localparam logic [5:0] LAST_INDEX = 6'(WORDS_PER_SAMPLE - 1);

   logic                busy_ff, busy_in;
   logic [5:0]          count_ff, count_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [INTEG_W-1:0]  integ_ff, integ_in;
   logic                out_valid_ff, out_valid_in;
   dds_rsp_type         out_word_ff, out_word_in;
   logic                step, load, at_last;

   assign at_last    = (count_ff == LAST_INDEX);
   assign step       = busy_ff && (!out_valid_ff || pop);
   // A queued sample is taken on the final step, so bursts follow without a gap.
   assign load       = !sample_empty && (!busy_ff || (step && at_last));
   assign sample_pop = load;
   assign empty      = !out_valid_ff;
   assign rsp_word   = out_word_ff;

   always_comb begin
      integ_in     = integ_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (step) begin
         integ_in     = integ_ff + INTEG_W'(sample_ff) - (integ_ff & LEVEL_MASK);
         out_valid_in = 1'b1;
         out_word_in.pin_pattern = level_to_pattern(integ_in[10:8]);
         out_word_in.word_index  = count_ff;
         out_word_in.last        = at_last;
         count_in = at_last ? 6'd0 : count_ff + 6'd1;
         if (at_last) begin
            busy_in = load;
         end
      end else begin
         if (pop) begin
            out_valid_in = 1'b0;
         end
         if (load) begin
            busy_in  = 1'b1;
            count_in = 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         integ_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         integ_ff     <= integ_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      if (load) begin
         sample_ff <= sample_value;
      end
   end

`ifndef SYNTHESIS
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      integ_ff[10:8] <= LEVEL_MAX)
      else $error("modulator level left its range");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_INDEX)
      else $error("word counter past the burst length");
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.last) |-> (out_word_ff.word_index == LAST_INDEX))
      else $error("last flag on a word that does not end the burst");
`endif

endmodule

// ----- rtl/core/dds_sigma_delta_tone_generator.sv -----
// Top level of the tone generator: front pipeline, sample queue and modulator.
//
//   channel   ports                        direction   word
//   request   push, full, req_word         in          dds_req_type
//   response  pop, empty, rsp_word         out         dds_rsp_type
//
// A tick yields WORDS_PER_SAMPLE words, one per cycle while popped, from the single
// modulator step, which paces ticks once the queue is full. Table writes are taken
// one per cycle while full is low; a tick passes the front stages, the queue and the
// sample register ahead of its first word. Reset clears the phase, the integrator and
// all queues; the wave table holds no value until written. A stalled response backs
// up into the queue and then the front pipeline, which raises full.
module dds_sigma_delta_tone_generator
   import dds_pkg::*;
#(
   parameter int unsigned SAMPLE_RATE_HZ   = 16000,
   parameter int unsigned WORDS_PER_SAMPLE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  dds_req_type req_word,
   output logic        empty,
   input  logic        pop,
   output dds_rsp_type rsp_word
);

   logic                q_push, q_full, q_pop, q_empty;
   logic [SAMPLE_W-1:0] q_push_data, q_pop_data;

   dds_front #(
      .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_word     (req_word),
      .sample_push  (q_push),
      .sample_value (q_push_data),
      .sample_full  (q_full)
   );

   dds_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   dds_back #(
      .WORDS_PER_SAMPLE(WORDS_PER_SAMPLE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .sample_empty (q_empty),
      .sample_value (q_pop_data),
      .sample_pop   (q_pop),
      .empty        (empty),
      .pop          (pop),
      .rsp_word     (rsp_word)
   );

endmodule
